@@ hdl/three_axis_offset_calibrator_top_defines.svh @@
`ifndef THREE_AXIS_OFFSET_CALIBRATOR_TOP_DEFINES_SVH
`define THREE_AXIS_OFFSET_CALIBRATOR_TOP_DEFINES_SVH

// same-cycle implication, skipped while in reset
`define TOC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while in reset
`define TOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/toc_pkg.sv @@
package toc_pkg;

  localparam int CFG_ADDR_BITS = 1;

  localparam logic [CFG_ADDR_BITS-1:0] REG_SAMPLE_COUNT = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_Z_BIAS       = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       start_en;   // start transfer: clear and load the countdown
    logic       acc_en;     // sample transfer during a run
    logic       load_imm;   // result of the transfer goes straight out
    logic       load_done;  // result of a finished run goes out
    logic       prep;       // form the dividend of the current axis
    logic       div_start;
    logic       off_wr;
    logic [1:0] axis;
  } ctrl_cmd_t;

  typedef struct packed {
    logic active;
    logic last;
    logic div_done;
  } dp_status_t;

endpackage

@@ hdl/toc_if.sv @@
interface toc_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, action, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, action, sample_x, sample_y, sample_z, output ready);
endinterface

interface toc_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] offset_x;
  logic signed [SAMPLE_BITS-1:0] offset_y;
  logic signed [SAMPLE_BITS-1:0] offset_z;
  logic                          busy_res;
  logic                          done_res;

  modport source (output valid, offset_x, offset_y, offset_z, busy_res, done_res,
                  input ready);
  modport sink   (input valid, offset_x, offset_y, offset_z, busy_res, done_res,
                  output ready);
endinterface

@@ hdl/toc_div.sv @@
module toc_div #(
  parameter int NW = 35,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic          neg,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;

  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // restoring division, one quotient bit a cycle
  assign shifted = {rem_r, q_r[NW-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NW-1];
      q_r   <= num[NW-1] ? (~num + 1'b1) : num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign done = done_r;
  assign neg  = neg_r;
  assign quot = q_r;

endmodule

@@ hdl/toc_dp.sv @@
module toc_dp #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  toc_pkg::ctrl_cmd_t                     cmd,
  output toc_pkg::dp_status_t                    status,
  input  logic signed [SAMPLE_BITS-1:0]          sample_x,
  input  logic signed [SAMPLE_BITS-1:0]          sample_y,
  input  logic signed [SAMPLE_BITS-1:0]          sample_z,
  input  logic                                   cfg_we,
  input  logic [toc_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
  input  logic [((COUNT_BITS > SAMPLE_BITS - 1) ? COUNT_BITS : SAMPLE_BITS - 1)-1:0]
                                                 cfg_wdata,
  output logic signed [SAMPLE_BITS-1:0]          offset_x,
  output logic signed [SAMPLE_BITS-1:0]          offset_y,
  output logic signed [SAMPLE_BITS-1:0]          offset_z,
  output logic                                   busy_res,
  output logic                                   done_res
);
  import toc_pkg::*;

  localparam int SW = SAMPLE_BITS + COUNT_BITS + 1;
  localparam int NW = SW + 2;
  localparam int DW = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_RST = COUNT_BITS'(1000);
  localparam logic [NW-1:0] MAG_MAX = NW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [SAMPLE_BITS-1:0] OFF_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] OFF_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [COUNT_BITS-1:0]         sample_count_r;
  logic [SAMPLE_BITS-2:0]        z_bias_r;
  logic [COUNT_BITS-1:0]         remaining_r;
  logic [COUNT_BITS-1:0]         run_len_r;
  logic signed [SW-1:0]          sum_x_r;
  logic signed [SW-1:0]          sum_y_r;
  logic signed [SW-1:0]          sum_z_r;
  logic signed [SAMPLE_BITS-1:0] off_x_r;
  logic signed [SAMPLE_BITS-1:0] off_y_r;
  logic signed [SAMPLE_BITS-1:0] off_z_r;
  logic [NW-1:0]                 num_r;

  logic signed [SAMPLE_BITS-1:0] out_x_r;
  logic signed [SAMPLE_BITS-1:0] out_y_r;
  logic signed [SAMPLE_BITS-1:0] out_z_r;
  logic                          out_busy_r;
  logic                          out_done_r;

  logic signed [SAMPLE_BITS:0]   z_term;
  logic signed [SW-1:0]          sum_sel;
  logic                          div_done;
  logic                          div_neg;
  logic [NW-1:0]                 quot;
  logic [SAMPLE_BITS-1:0]        off_sat;
  logic                          busy_imm;

  assign z_term = (SAMPLE_BITS+1)'(sample_z) - $signed({2'b00, z_bias_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= COUNT_RST;
      z_bias_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[COUNT_BITS-1:0];
        REG_Z_BIAS:       z_bias_r       <= cfg_wdata[SAMPLE_BITS-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.axis)
      AXIS_X:  sum_sel = sum_x_r;
      AXIS_Y:  sum_sel = sum_y_r;
      default: sum_sel = sum_z_r;
    endcase
  end

  // round to nearest (half up) for a non-negative sum by dividing 2*sum + n by 2*n
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num_r <= {sum_sel[SW-1], sum_sel, 1'b0} + {{(NW-COUNT_BITS){1'b0}}, run_len_r};
    end
  end

  toc_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   ({run_len_r, 1'b0}),
    .done  (div_done),
    .neg   (div_neg),
    .quot  (quot)
  );

  always_comb begin
    if (div_neg) begin
      off_sat = (quot > MAG_MAX + 1'b1) ? OFF_MIN : (~quot[SAMPLE_BITS-1:0] + 1'b1);
    end else begin
      off_sat = (quot > MAG_MAX) ? OFF_MAX : quot[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      run_len_r   <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      off_x_r     <= '0;
      off_y_r     <= '0;
      off_z_r     <= '0;
    end else begin
      if (cmd.start_en) begin
        remaining_r <= sample_count_r;
        run_len_r   <= sample_count_r;
        sum_x_r     <= '0;
        sum_y_r     <= '0;
        sum_z_r     <= '0;
        off_x_r     <= '0;
        off_y_r     <= '0;
        off_z_r     <= '0;
      end else if (cmd.acc_en) begin
        remaining_r <= remaining_r - 1'b1;
        sum_x_r     <= sum_x_r + SW'(sample_x);
        sum_y_r     <= sum_y_r + SW'(sample_y);
        sum_z_r     <= sum_z_r + SW'(z_term);
      end else if (cmd.off_wr) begin
        case (cmd.axis)
          AXIS_X:  off_x_r <= off_sat;
          AXIS_Y:  off_y_r <= off_sat;
          default: off_z_r <= off_sat;
        endcase
      end
    end
  end

  // a run stays busy after a start with a nonzero count or a non-final sample
  assign busy_imm = cmd.start_en ? (sample_count_r != '0) : cmd.acc_en;

  always_ff @(posedge clk) begin
    if (cmd.load_imm) begin
      out_x_r    <= cmd.start_en ? '0 : off_x_r;
      out_y_r    <= cmd.start_en ? '0 : off_y_r;
      out_z_r    <= cmd.start_en ? '0 : off_z_r;
      out_busy_r <= busy_imm;
      out_done_r <= 1'b0;
    end else if (cmd.load_done) begin
      out_x_r    <= off_x_r;
      out_y_r    <= off_y_r;
      out_z_r    <= off_z_r;
      out_busy_r <= 1'b0;
      out_done_r <= 1'b1;
    end
  end

  assign status.active   = remaining_r != '0;
  assign status.last     = remaining_r == COUNT_BITS'(1);
  assign status.div_done = div_done;

  assign offset_x = out_x_r;
  assign offset_y = out_y_r;
  assign offset_z = out_z_r;
  assign busy_res = out_busy_r;
  assign done_res = out_done_r;

endmodule

@@ hdl/toc_ctrl.sv @@
module toc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  toc_pkg::dp_status_t status,
  output toc_pkg::ctrl_cmd_t  cmd
);
  import toc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [1:0] axis_r;
  logic [1:0] axis_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;
  logic       accept;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action) begin
            cmd.start_en = 1'b1;
            cmd.load_imm = 1'b1;
          end else if (status.active) begin
            cmd.acc_en = 1'b1;
            if (status.last) begin
              state_nxt = S_PREP;
              axis_nxt  = AXIS_X;
            end else begin
              cmd.load_imm = 1'b1;
            end
          end else begin
            cmd.load_imm = 1'b1;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (status.div_done) begin
          cmd.off_wr = 1'b1;
          if (axis_r == AXIS_Z) begin
            state_nxt = S_OUT;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = S_PREP;
          end
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.load_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (cmd.load_imm || cmd.load_done) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ hdl/three_axis_offset_calibrator_top.sv @@
// channel  direction  payload                                        handshake
// in_ch    sink       action, sample_x, sample_y, sample_z           valid/ready
// out_ch   source     offset_x, offset_y, offset_z, busy_res,        valid/ready
//                     done_res
// cfg      write      cfg_addr, cfg_wdata                            cfg_we
//
// start items, ignored samples and non-final samples leave the controller in its idle state
// the final sample of a run blocks further items until three serial divisions are done:
// one shared serial divider resolves one quotient bit a cycle, axis by axis
// an item is taken only when the output register is empty or drained in that cycle
// rst_n is synchronous; no clearing pass is needed after it
module three_axis_offset_calibrator_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  toc_in_if.sink                                 in_ch,
  toc_out_if.source                              out_ch,
  input  logic                                   cfg_we,
  input  logic [toc_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
  input  logic [((COUNT_BITS > SAMPLE_BITS - 1) ? COUNT_BITS : SAMPLE_BITS - 1)-1:0]
                                                 cfg_wdata
);
  import toc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  toc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  toc_dp #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .sample_x  (in_ch.sample_x),
    .sample_y  (in_ch.sample_y),
    .sample_z  (in_ch.sample_z),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .offset_x  (out_ch.offset_x),
    .offset_y  (out_ch.offset_y),
    .offset_z  (out_ch.offset_z),
    .busy_res  (out_ch.busy_res),
    .done_res  (out_ch.done_res)
  );

endmodule

@@ hdl/toc_checker.sv @@
`include "three_axis_offset_calibrator_top_defines.svh"

module toc_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_action,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] offset_x,
  input logic [SAMPLE_BITS-1:0] offset_y,
  input logic [SAMPLE_BITS-1:0] offset_z,
  input logic                   busy_res,
  input logic                   done_res
);

  // a waiting result holds still
  `TOC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(offset_x) && $stable(offset_y) && $stable(offset_z) && $stable(busy_res) && $stable(done_res), "result changed while stalled")

  // no new transfer while an unread result blocks the output register
  `TOC_ASSERT_SAME(a_no_overrun, clk, rst_n, in_ready, !out_valid || out_ready, "input ready while output full")

  // a start gives zero offsets on the very next cycle
  `TOC_ASSERT_NEXT(a_start_clears, clk, rst_n, in_valid && in_ready && in_action, out_valid && offset_x == '0 && offset_y == '0 && offset_z == '0 && !done_res, "start did not clear offsets")

  // a finished run is never still busy
  `TOC_ASSERT_SAME(a_done_idle, clk, rst_n, out_valid && done_res, !busy_res, "done result flagged busy")

endmodule

bind three_axis_offset_calibrator_top toc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_toc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .offset_x  (out_ch.offset_x),
  .offset_y  (out_ch.offset_y),
  .offset_z  (out_ch.offset_z),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res)
);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import toc_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int CFG_W = (COUNT_BITS > SAMPLE_BITS - 1) ? COUNT_BITS : SAMPLE_BITS - 1;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_START  = 1'b1;

  localparam logic signed [SAMPLE_BITS-1:0] READING_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] READING_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam longint OFFSET_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint OFFSET_MIN = -OFFSET_MAX - 1;

  localparam logic [COUNT_BITS-1:0]    COUNT_AT_RESET = 1000;
  localparam logic [COUNT_BITS-1:0]    COUNT_LONGEST  = {COUNT_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-2:0]   BIAS_LARGEST   = {(SAMPLE_BITS-1){1'b1}};

  // final sample of a run waits for three serial divisions
  localparam int DIV_LATENCY  = 3 * (SAMPLE_BITS + COUNT_BITS + 6) + 2;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int IDLE_PERCENT = 34;

  typedef struct {
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
  } sample_item_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] off_x;
    logic signed [SAMPLE_BITS-1:0] off_y;
    logic signed [SAMPLE_BITS-1:0] off_z;
    logic                          busy;
    logic                          done;
  } offset_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  toc_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_bus ();
  toc_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_bus ();

  three_axis_offset_calibrator_top #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  sample_item_t   pending_samples[$];
  offset_result_t expected_offsets[$];
  int             mismatches = 0;
  logic           in_fired;
  logic           calm;

  // predictor state and its copy of the registers
  logic [COUNT_BITS-1:0]  cal_count;
  logic [SAMPLE_BITS-2:0] cal_bias;
  longint                 acc_x = 0, acc_y = 0, acc_z = 0;
  logic [COUNT_BITS-1:0]  remaining = '0;
  logic [COUNT_BITS-1:0]  run_len = '0;
  logic signed [SAMPLE_BITS-1:0] off_x = '0, off_y = '0, off_z = '0;

  always #10 clk = ~clk;

  function automatic logic signed [SAMPLE_BITS-1:0] rounded_mean(input longint total,
                                                                 input longint n);
    longint q;
    // division truncates toward zero, which rounds the average half up only when it is non-negative
    q = (2 * total + n) / (2 * n);
    if (q > OFFSET_MAX) q = OFFSET_MAX;
    if (q < OFFSET_MIN) q = OFFSET_MIN;
    return q[SAMPLE_BITS-1:0];
  endfunction

  function automatic void predict_offsets(input sample_item_t it);
    offset_result_t r;
    logic           done;
    done = 1'b0;
    if (it.action == ACT_START) begin
      off_x = '0;
      off_y = '0;
      off_z = '0;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      run_len = cal_count;
      remaining = cal_count;
    end else if (remaining != 0) begin
      acc_x += longint'(it.x);
      acc_y += longint'(it.y);
      acc_z += longint'(it.z) - longint'({1'b0, cal_bias});
      if (remaining == 1 && run_len != 0) begin
        off_x = rounded_mean(acc_x, longint'({1'b0, run_len}));
        off_y = rounded_mean(acc_y, longint'({1'b0, run_len}));
        off_z = rounded_mean(acc_z, longint'({1'b0, run_len}));
        done = 1'b1;
      end
      remaining = remaining - 1'b1;
    end
    r.off_x = off_x;
    r.off_y = off_y;
    r.off_z = off_z;
    r.busy  = (remaining != 0);
    r.done  = done;
    expected_offsets.push_back(r);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_reading();
    case ($urandom_range(0, 9))
      0: return READING_MAX;
      1: return READING_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic side_pauses();
    return !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  task automatic queue_item(input logic act, input logic signed [SAMPLE_BITS-1:0] x,
                            input logic signed [SAMPLE_BITS-1:0] y,
                            input logic signed [SAMPLE_BITS-1:0] z);
    sample_item_t it;
    it.action = act;
    it.x = x;
    it.y = y;
    it.z = z;
    pending_samples.push_back(it);
  endtask

  task automatic queue_random(input logic act);
    queue_item(act, pick_reading(), pick_reading(), pick_reading());
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || expected_offsets.size() != 0 || in_bus.valid);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_SAMPLE_COUNT) cal_count = val[COUNT_BITS-1:0];
    else cal_bias = val[SAMPLE_BITS-2:0];
  endtask

  // registers change only once everything in flight has come back
  task automatic set_calibration(input logic [COUNT_BITS-1:0] count,
                                 input logic [SAMPLE_BITS-2:0] bias);
    wait_drained();
    write_reg(REG_SAMPLE_COUNT, CFG_W'(count));
    write_reg(REG_Z_BIAS, CFG_W'(bias));
    @(posedge clk);
  endtask

  task automatic fill_random(input int n_items);
    int made;
    int run;
    int extra;
    int k;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        run = cal_count;
        // now and then a run is abandoned by the next start
        if ($urandom_range(0, 9) == 0) run = $urandom_range(0, run);
        queue_random(ACT_START);
        for (k = 0; k < run; k++) queue_random(ACT_SAMPLE);
        extra = $urandom_range(0, 2);
        repeat (extra) queue_random(ACT_SAMPLE);
        made += run + 1 + extra;
      end else begin
        queue_random(1'($urandom));
        made++;
      end
    end
  endtask

  task automatic run_phase(input logic [COUNT_BITS-1:0] count,
                           input logic [SAMPLE_BITS-2:0] bias, input int n_items,
                           input logic quiet);
    set_calibration(count, bias);
    calm = quiet;
    fill_random(n_items);
    wait_drained();
    calm = 1'b0;
  endtask

  // sender: holds an item until its transfer, then takes the next
  always @(negedge clk) begin : drive_samples
    sample_item_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !in_fired) begin
      // held until the transfer
    end else if (pending_samples.size() != 0 && !side_pauses()) begin
      nxt = pending_samples.pop_front();
      in_bus.valid    <= 1'b1;
      in_bus.action   <= nxt.action;
      in_bus.sample_x <= nxt.x;
      in_bus.sample_y <= nxt.y;
      in_bus.sample_z <= nxt.z;
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_bus.ready <= rst_n && !side_pauses();
  end

  always @(posedge clk) begin : take_samples
    sample_item_t it;
    in_fired <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      it.action = in_bus.action;
      it.x = in_bus.sample_x;
      it.y = in_bus.sample_y;
      it.z = in_bus.sample_z;
      predict_offsets(it);
    end
  end

  always @(posedge clk) begin : check_offsets
    offset_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_offsets.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result x=%0d y=%0d z=%0d busy=%b done=%b",
                   out_bus.offset_x, out_bus.offset_y, out_bus.offset_z,
                   out_bus.busy_res, out_bus.done_res);
        mismatches++;
      end else begin
        want = expected_offsets.pop_front();
        if (out_bus.offset_x !== want.off_x || out_bus.offset_y !== want.off_y ||
            out_bus.offset_z !== want.off_z || out_bus.busy_res !== want.busy ||
            out_bus.done_res !== want.done) begin
          if (mismatches < 10)
            $display("mismatch: expected x=%0d y=%0d z=%0d busy=%b done=%b,",
                     want.off_x, want.off_y, want.off_z, want.busy, want.done,
                     " got x=%0d y=%0d z=%0d busy=%b done=%b",
                     out_bus.offset_x, out_bus.offset_y, out_bus.offset_z,
                     out_bus.busy_res, out_bus.done_res);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("three_axis_offset_calibrator_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    int k;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    cal_count = COUNT_AT_RESET;
    cal_bias = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // samples while idle are ignored
    queue_item(ACT_SAMPLE, READING_MAX, READING_MAX, READING_MAX);
    queue_item(ACT_SAMPLE, READING_MIN, READING_MIN, READING_MIN);
    // run of reset length, left unfinished
    queue_item(ACT_START, READING_MAX, READING_MIN, READING_MAX);
    queue_item(ACT_SAMPLE, 1, 2, 3);
    queue_item(ACT_SAMPLE, -5, 7, -9);

    // single-sample run restarts the unfinished one
    set_calibration(1, 0);
    queue_item(ACT_START, READING_MIN, READING_MAX, READING_MIN);
    queue_item(ACT_SAMPLE, READING_MAX, READING_MIN, READING_MIN);

    // largest bias drives the z average below range; y rounds toward zero
    set_calibration(2, BIAS_LARGEST);
    queue_item(ACT_START, 0, 0, 0);
    queue_item(ACT_SAMPLE, READING_MAX, -1, READING_MIN);
    queue_item(ACT_SAMPLE, READING_MAX, -3, READING_MIN);
    queue_item(ACT_SAMPLE, 4, 4, 4);

    // start in the middle of a run
    set_calibration(3, 100);
    queue_item(ACT_START, 9, 9, 9);
    queue_item(ACT_SAMPLE, 1, 1, 1);
    queue_item(ACT_START, -9, -9, -9);
    queue_item(ACT_SAMPLE, 1, -1, 200);
    queue_item(ACT_SAMPLE, 2, -2, 0);
    queue_item(ACT_SAMPLE, -4, 5, READING_MAX);

    // zero run length: offsets cleared, nothing averaged
    set_calibration(0, 0);
    queue_item(ACT_START, 1, 1, 1);
    queue_item(ACT_SAMPLE, 7, 7, 7);

    // run length changed mid-run only counts from the next start
    set_calibration(2, 0);
    queue_item(ACT_START, 0, 0, 0);
    queue_item(ACT_SAMPLE, 11, -11, 3);
    wait_drained();
    write_reg(REG_SAMPLE_COUNT, CFG_W'(5));
    @(posedge clk);
    queue_item(ACT_SAMPLE, 12, -12, 4);

    run_phase(1, 0, 100, 1'b0);
    run_phase(4, 16384, 150, 1'b0);
    run_phase(COUNT_BITS'($urandom_range(2, 10)),
              (SAMPLE_BITS-1)'($urandom_range(0, 32767)), 150, 1'b0);

    // longest run length, abandoned after a few samples by the next start
    set_calibration(COUNT_LONGEST, BIAS_LARGEST);
    queue_random(ACT_START);
    for (k = 0; k < 8; k++) queue_random(ACT_SAMPLE);
    wait_drained();

    run_phase(0, (SAMPLE_BITS-1)'($urandom_range(0, 32767)), 40, 1'b0);
    run_phase(3, BIAS_LARGEST, 150, 1'b1);
    run_phase(COUNT_BITS'($urandom_range(1, 30)),
              (SAMPLE_BITS-1)'($urandom_range(0, 32767)), 200, 1'b0);
    run_phase(2, 0, 100, 1'b0);

    wait_drained();
    repeat (DIV_LATENCY + 40) @(posedge clk);
    if (mismatches == 0 && expected_offsets.size() == 0) begin
      $display("three_axis_offset_calibrator_top regression: pass");
    end else begin
      $display("three_axis_offset_calibrator_top regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/toc_pkg.sv
hdl/toc_if.sv
hdl/toc_div.sv
hdl/toc_dp.sv
hdl/toc_ctrl.sv
hdl/three_axis_offset_calibrator_top.sv
hdl/toc_checker.sv
tb/tb_top.sv
